/* sv/tiru_pkg.sv */
// Shared constants and operation codes for the tick tagged input ring.
package tiru_pkg;

    localparam int SLOT_COUNT_DEFAULT = 64;

    localparam int OP_W      = 3;
    localparam int TICK_W    = 32;
    localparam int PAYLOAD_W = 32;
    localparam int ENTRY_W   = TICK_W + PAYLOAD_W;

    // residue fold: bits per cycle and cycles per tick
    localparam int MOD_STEPS  = 8;
    localparam int MOD_CYCLES = TICK_W / MOD_STEPS;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    localparam logic [OP_W-1:0] OP_ADD          = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd1;
    localparam logic [OP_W-1:0] OP_ACK          = 3'd2;
    localparam logic [OP_W-1:0] OP_GET          = 3'd3;
    localparam logic [OP_W-1:0] OP_REPLAY_AFTER = 3'd4;
    localparam logic [OP_W-1:0] OP_REPLAY_UNACK = 3'd5;

endpackage

/* sv/tiru_ram.sv */
// Generic single-port RAM with registered read data.
module tiru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/tick_tagged_input_ring_unit.sv */
// Top level of the tick tagged input ring: sequencer, valid bits and slot RAM.
//
// Usage: one request transfer on the s_ channel (s_tuser = operation, s_tdata =
// tick and payload) is taken only while the unit is idle. Results leave on the
// m_ channel through an output register; m_tlast marks the end of a get or replay.
// Add and get: accept, a fold that reduces the tick to a slot index (8 bits per
// cycle), RAM read and execute; a get waits in execute for a free output register
// and its result is presented on the cycle after execute, then the unit is idle.
// Clear, acknowledge and unused codes finish in the accept cycle.
// Replay: repeated minimum search passes over the slot RAM, one read per cycle
// within a pass; n results take n + 1 passes. The single RAM port sets that rate.
// Reset clears the valid bits, the three tick registers and all control state;
// slot contents need no clearing. When the receiver stalls, the unit holds its
// result in the output register and waits before producing the next one.
module tick_tagged_input_ring_unit #(
    parameter int SLOT_COUNT = tiru_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // tick [31:0], payload [63:32]
    input  logic [2:0]  s_tuser,   // operation [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // entry_tick [31:0], entry_payload [63:32]
    output logic [0:0]  m_tuser,   // found [0]
    output logic        m_tlast
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int TW     = tiru_pkg::TICK_W;
    localparam int PW     = tiru_pkg::PAYLOAD_W;
    localparam logic [SLOT_W:0] SLOT_N   = (SLOT_W+1)'(SLOT_COUNT);
    localparam logic [TW-1:0]   SLOT_N32 = TW'(SLOT_COUNT);
    localparam logic [tiru_pkg::MOD_CNT_W-1:0] MOD_LAST =
        tiru_pkg::MOD_CNT_W'(tiru_pkg::MOD_CYCLES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SDONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [SLOT_COUNT-1:0] slot_valid_reg, slot_valid_next;
    logic [TW-1:0] oldest_reg, oldest_next;
    logic [TW-1:0] newest_reg, newest_next;
    logic [TW-1:0] acked_reg, acked_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic pend_valid_reg, pend_valid_next;
    logic best_found_reg, best_found_next;
    logic rd_v_reg, rd_v_next;
    logic [SLOT_W:0] issue_cnt_reg, issue_cnt_next;
    logic [tiru_pkg::MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;

    logic [tiru_pkg::OP_W-1:0] op_reg, op_next;
    logic [TW-1:0] tick_reg, tick_next;
    logic [PW-1:0] payload_reg, payload_next;
    logic [TW-1:0] mod_word_reg, mod_word_next;
    logic [SLOT_W-1:0] mod_rem_reg, mod_rem_next;
    logic [TW:0] lower_reg, lower_next;
    logic [TW-1:0] best_tick_reg, best_tick_next;
    logic [PW-1:0] best_pay_reg, best_pay_next;
    logic [TW-1:0] pend_tick_reg, pend_tick_next;
    logic [PW-1:0] pend_pay_reg, pend_pay_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic m_tuser_reg, m_tuser_next;
    logic m_tlast_reg, m_tlast_next;
    logic valid_q_reg;

    logic ram_we;
    logic [SLOT_W-1:0] ram_addr;
    logic [tiru_pkg::ENTRY_W-1:0] ram_wdata, ram_q;
    logic [TW-1:0] q_tick;
    logic [PW-1:0] q_pay;

    logic [SLOT_W:0] fold;
    logic [SLOT_W-1:0] mod_fold;
    logic out_free, issue_done, cand_ok, cand_better, get_hit;

    tiru_ram #(
        .WIDTH(tiru_pkg::ENTRY_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .clk  (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_q)
    );

    assign q_tick = ram_q[tiru_pkg::ENTRY_W-1:PW];
    assign q_pay  = ram_q[PW-1:0];

    // tick mod SLOT_COUNT, MSB first, one conditional subtract per bit
    always_comb begin
        fold = {1'b0, mod_rem_reg};
        for (int i = 0; i < tiru_pkg::MOD_STEPS; i++) begin
            fold = {fold[SLOT_W-1:0], mod_word_reg[TW-1-i]};
            if (fold >= SLOT_N) begin
                fold = fold - SLOT_N;
            end
        end
        mod_fold = fold[SLOT_W-1:0];
    end

    assign out_free    = !m_tvalid_reg || m_tready;
    assign issue_done  = (issue_cnt_reg == SLOT_N);
    assign cand_ok     = rd_v_reg && valid_q_reg && ({1'b0, q_tick} >= lower_reg) &&
                         (q_tick >= oldest_reg) && (q_tick <= newest_reg);
    assign cand_better = !best_found_reg || (q_tick < best_tick_reg);
    assign get_hit     = (tick_reg >= oldest_reg) && (tick_reg <= newest_reg) &&
                         valid_q_reg && (q_tick == tick_reg);

    always_comb begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        oldest_next     = oldest_reg;
        newest_next     = newest_reg;
        acked_next      = acked_reg;
        m_tvalid_next   = m_tvalid_reg;
        pend_valid_next = pend_valid_reg;
        best_found_next = best_found_reg;
        rd_v_next       = 1'b0;
        issue_cnt_next  = issue_cnt_reg;
        mod_cnt_next    = mod_cnt_reg;
        op_next         = op_reg;
        tick_next       = tick_reg;
        payload_next    = payload_reg;
        mod_word_next   = mod_word_reg;
        mod_rem_next    = mod_rem_reg;
        lower_next      = lower_reg;
        best_tick_next  = best_tick_reg;
        best_pay_next   = best_pay_reg;
        pend_tick_next  = pend_tick_reg;
        pend_pay_next   = pend_pay_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        ram_we          = 1'b0;
        ram_addr        = mod_rem_reg;
        ram_wdata       = {tick_reg, payload_reg};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next        = s_tuser;
                    tick_next      = s_tdata[TW-1:0];
                    payload_next   = s_tdata[TW+PW-1:TW];
                    mod_word_next  = s_tdata[TW-1:0];
                    mod_rem_next   = '0;
                    mod_cnt_next   = '0;
                    issue_cnt_next = '0;
                    best_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    case (s_tuser) inside
                        tiru_pkg::OP_ADD, tiru_pkg::OP_GET: begin
                            state_next = ST_MOD;
                        end
                        tiru_pkg::OP_CLEAR: begin
                            slot_valid_next = '0;
                            oldest_next     = '0;
                            newest_next     = '0;
                            acked_next      = '0;
                        end
                        tiru_pkg::OP_ACK: begin
                            if (s_tdata[TW-1:0] > acked_reg) begin
                                acked_next = s_tdata[TW-1:0];
                            end
                        end
                        tiru_pkg::OP_REPLAY_AFTER: begin
                            lower_next = {1'b0, s_tdata[TW-1:0]} + 1'b1;
                            state_next = ST_SCAN;
                        end
                        tiru_pkg::OP_REPLAY_UNACK: begin
                            lower_next = {1'b0, acked_reg} + 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD: begin
                mod_rem_next  = mod_fold;
                mod_word_next = mod_word_reg << tiru_pkg::MOD_STEPS;
                mod_cnt_next  = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_LAST) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (op_reg == tiru_pkg::OP_ADD) begin
                    if (valid_q_reg && (q_tick < tick_reg)) begin
                        oldest_next = (tick_reg > SLOT_N32) ?
                                      (tick_reg - SLOT_N32 + 1'b1) : TW'(1);
                    end else if (oldest_reg == '0) begin
                        oldest_next = tick_reg;
                    end
                    ram_we                       = 1'b1;
                    slot_valid_next[mod_rem_reg] = 1'b1;
                    newest_next                  = tick_reg;
                    state_next                   = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = get_hit;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = get_hit ? {q_pay, q_tick} : '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!issue_done) begin
                    ram_addr       = issue_cnt_reg[SLOT_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_v_next      = 1'b1;
                end else begin
                    ram_addr = '0;
                end
                if (cand_ok && cand_better) begin
                    best_found_next = 1'b1;
                    best_tick_next  = q_tick;
                    best_pay_next   = q_pay;
                end
                if (issue_done && !rd_v_reg) begin
                    state_next = ST_SDONE;
                end
            end
            ST_SDONE: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = 1'b1;
                        m_tlast_next  = !best_found_reg;
                        m_tdata_next  = {pend_pay_reg, pend_tick_reg};
                    end else if (!best_found_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tuser_next  = 1'b0;
                        m_tlast_next  = 1'b1;
                        m_tdata_next  = '0;
                    end
                    if (best_found_reg) begin
                        pend_valid_next = 1'b1;
                        pend_tick_next  = best_tick_reg;
                        pend_pay_next   = best_pay_reg;
                        lower_next      = {1'b0, best_tick_reg} + 1'b1;
                        best_found_next = 1'b0;
                        issue_cnt_next  = '0;
                        state_next      = ST_SCAN;
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            acked_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            best_found_reg <= 1'b0;
            rd_v_reg       <= 1'b0;
            issue_cnt_reg  <= '0;
            mod_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            oldest_reg     <= oldest_next;
            newest_reg     <= newest_next;
            acked_reg      <= acked_next;
            m_tvalid_reg   <= m_tvalid_next;
            pend_valid_reg <= pend_valid_next;
            best_found_reg <= best_found_next;
            rd_v_reg       <= rd_v_next;
            issue_cnt_reg  <= issue_cnt_next;
            mod_cnt_reg    <= mod_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        tick_reg      <= tick_next;
        payload_reg   <= payload_next;
        mod_word_reg  <= mod_word_next;
        mod_rem_reg   <= mod_rem_next;
        lower_reg     <= lower_next;
        best_tick_reg <= best_tick_next;
        best_pay_reg  <= best_pay_next;
        pend_tick_reg <= pend_tick_next;
        pend_pay_reg  <= pend_pay_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
        valid_q_reg   <= slot_valid_reg[ram_addr];
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == '0 && m_tlast_reg))
        else $error("not-found result carries data or lacks last");

    a_best_above_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        best_found_reg |-> ({1'b0, best_tick_reg} >= lower_reg))
        else $error("scan minimum below replay bound");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && $past(aresetn) && $past(state_reg) == ST_SDONE) |-> !pend_valid_reg)
        else $error("replay ended with a pending result");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= SLOT_N))
        else $error("scan counter past slot count");
`endif

endmodule
